### design/assert_macros.svh
// assertion helpers shared by the checker
`ifndef ASSERT_MACROS_SVH
`define ASSERT_MACROS_SVH

// property checked on every rising edge, off while reset is held
`define RSLR_ASSERT(name, clk, rst_n, prop) \
  name: assert property (@(posedge clk) disable iff (!rst_n) prop) \
    else $error("rslr check failed");

// property checked on every rising edge, reset included
`define RSLR_ASSERT_ALWAYS(name, clk, prop) \
  name: assert property (@(posedge clk) prop) else $error("rslr check failed");

`endif

### design/rslr_pkg.sv
package rslr_pkg;

  localparam int NCH          = 8;
  localparam int CHANNELS_DEF = 8;
  localparam int ROW_LIMIT_DEF = 4096;

  localparam logic [25:0] MARGIN_US  = 26'd1000;
  localparam logic [19:0] US_PER_S   = 20'd1000000;
  localparam logic [24:0] COARSE_RST = 25'd4096000;

  typedef enum logic [1:0] {
    REG_COARSE  = 2'd0,
    REG_FIRST   = 2'd1,
    REG_LAST    = 2'd2,
    REG_TRIGGER = 2'd3
  } reg_idx_e;

  typedef struct packed {
    logic [49:0]             start;
    logic [49:0]             stop;
    logic [NCH-1:0][23:0]    counts;
    logic [24:0]             expo;
    logic                    trig;
    logic                    seg;
  } bin_t;

  typedef struct packed {
    logic [49:0] start;
    logic [49:0] stop;
    logic        trig;
    logic        seg;
  } bin_tag_t;

endpackage

### design/rslr_lane.sv
module rslr_lane (
  input  logic        clk_i,
  input  logic        rst_ni,
  input  logic        start_i,
  input  logic [23:0] counts_i,
  input  logic [24:0] expo_i,
  output logic        busy_o,
  output logic [31:0] rate_o
);

  typedef enum logic [1:0] {L_IDLE, L_MUL, L_DIV} lane_state_e;

  lane_state_e state_q;
  logic [43:0] prod_q;
  logic [24:0] expo_q;
  logic [24:0] rem_q;
  logic [31:0] sh_q;
  logic [31:0] quo_q;
  logic [3:0]  cnt_q;
  logic [31:0] rate_q;

  logic [25:0] t1, t2;
  logic [24:0] r1, r2;
  logic        q1, q2;

  // two restoring steps per cycle, remainder always below the exposure
  always_comb begin
    t1 = {rem_q, sh_q[31]};
    q1 = (t1 >= {1'b0, expo_q});
    r1 = q1 ? 25'(t1 - {1'b0, expo_q}) : t1[24:0];
    t2 = {r1, sh_q[30]};
    q2 = (t2 >= {1'b0, expo_q});
    r2 = q2 ? 25'(t2 - {1'b0, expo_q}) : t2[24:0];
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      state_q <= L_IDLE;
      prod_q  <= '0;
      expo_q  <= '0;
      rem_q   <= '0;
      sh_q    <= '0;
      quo_q   <= '0;
      cnt_q   <= '0;
      rate_q  <= '0;
    end else begin
      unique case (state_q)
        L_IDLE: begin
          if (start_i) begin
            prod_q  <= 44'(counts_i * rslr_pkg::US_PER_S);
            expo_q  <= expo_i;
            state_q <= L_MUL;
          end
        end
        L_MUL: begin
          // numerator is prod * 256; its top 20 bits decide overflow
          if (expo_q == '0 || {5'b0, prod_q[43:24]} >= expo_q) begin
            rate_q  <= '1;
            state_q <= L_IDLE;
          end else begin
            rem_q   <= {5'b0, prod_q[43:24]};
            sh_q    <= {prod_q[23:0], 8'b0};
            quo_q   <= '0;
            cnt_q   <= '0;
            state_q <= L_DIV;
          end
        end
        L_DIV: begin
          rem_q <= r2;
          sh_q  <= {sh_q[29:0], 2'b00};
          quo_q <= {quo_q[29:0], q1, q2};
          cnt_q <= cnt_q + 4'd1;
          if (cnt_q == 4'd15) begin
            rate_q  <= {quo_q[29:0], q1, q2};
            state_q <= L_IDLE;
          end
        end
        default: state_q <= L_IDLE;
      endcase
    end
  end

  assign busy_o = (state_q != L_IDLE);
  assign rate_o = rate_q;

endmodule

### design/rslr_merge.sv
module rslr_merge (
  input  logic                                 clk_i,
  input  logic                                 rst_ni,
  input  logic                                 load_i,
  input  rslr_pkg::bin_tag_t                   tag_i,
  input  logic [rslr_pkg::NCH-1:0][31:0]       rates_i,
  output logic                                 ready_o,
  output logic                                 m_axis_tvalid,
  input  logic                                 m_axis_tready,
  output logic [359:0]                         m_axis_tdata,
  output logic                                 m_axis_tlast,
  output logic                                 m_axis_tuser
);

  logic         valid_q;
  logic [359:0] data_q;
  logic         last_q;
  logic         user_q;

  assign ready_o = !valid_q || m_axis_tready;

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      valid_q <= 1'b0;
    end else if (load_i) begin
      valid_q <= 1'b1;
    end else if (m_axis_tready) begin
      valid_q <= 1'b0;
    end
  end

  always_ff @(posedge clk_i) begin
    if (load_i) begin
      data_q <= {4'b0, rates_i, tag_i.stop, tag_i.start};
      last_q <= tag_i.seg;
      user_q <= tag_i.trig;
    end
  end

  assign m_axis_tvalid = valid_q;
  assign m_axis_tdata  = data_q;
  assign m_axis_tlast  = last_q;
  assign m_axis_tuser  = user_q;

endmodule

### design/spectrum_livetime_rebinner_unit.sv
// spectrum live-time rebinner
// s_axis carries one count row per beat (start, stop, exposure, eight channel
// counts); tlast marks the last row of a segment. m_axis carries one bin per
// beat: start, stop and eight rates in counts per second with 8 fraction
// bits; tuser flags a fine bin that spans the trigger time, tlast the last
// bin of a segment. Registers sit on the APB port at byte addresses 0, 8, 16
// and 24. The user must write them only while the block is idle; the block
// does not enforce this. A row is decided in the cycle it is accepted and
// gives zero, one or two bins. Each bin passes a launch, a multiply, the
// radix-4 divider in every channel lane, a lanes-done check and a load of
// the output register. A row that gives no bin is followed by the next row
// in the next cycle; a two-bin row holds the input until both are loaded.
// Reset clears the open bin, the row counter and the registers to their
// defaults. When the receiver stalls, the finished bin waits in the output
// register while the next bin is worked out; only then does the input stall.
module spectrum_livetime_rebinner_unit #(
  parameter int CHANNELS  = rslr_pkg::CHANNELS_DEF,
  parameter int ROW_LIMIT = rslr_pkg::ROW_LIMIT_DEF
) (
  input  logic         clk_i,
  input  logic         rst_ni,
  input  logic         s_axis_tvalid,
  output logic         s_axis_tready,
  // row_start, row_stop, row_exposure, count_ch0 .. count_ch7
  input  logic [255:0] s_axis_tdata,
  input  logic         s_axis_tlast,
  output logic         m_axis_tvalid,
  input  logic         m_axis_tready,
  // bin_start, bin_stop, rate_ch0 .. rate_ch7
  output logic [359:0] m_axis_tdata,
  output logic         m_axis_tlast,
  // holds_trigger
  output logic         m_axis_tuser,
  input  logic         psel,
  input  logic         penable,
  input  logic         pwrite,
  input  logic [4:0]   paddr,
  input  logic [63:0]  pwdata,
  output logic [63:0]  prdata,
  output logic         pready
);

  localparam int NCH = rslr_pkg::NCH;
  localparam int RCW = $clog2(ROW_LIMIT + 1);

  typedef enum logic [1:0] {S_IDLE, S_LOAD, S_DIV, S_PUT} state_e;

  state_e      state_q;
  logic        k_q;
  logic [1:0]  njobs_q, njobs_d;
  rslr_pkg::bin_t job_q [2];
  rslr_pkg::bin_t job0_d, job1_d;

  logic [24:0] coarse_q;
  logic [11:0] first_q, last_q;
  logic [49:0] trigger_q;

  logic [RCW-1:0]           rc_q, rc_d;
  logic                     open_q, open_d;
  logic [NCH-1:0][23:0]     acc_q, acc_d;
  logic [24:0]              expo_q, expo_d;
  logic [24:0]              dur_q, dur_d;
  logic [49:0]              ostart_q, ostart_d;
  logic [49:0]              ostop_q, ostop_d;

  logic                     s_acc;
  logic                     lane_start;
  logic [NCH-1:0]           lane_busy;
  logic [NCH-1:0][31:0]     rates;
  logic                     merge_ready;
  logic                     merge_load;
  rslr_pkg::bin_t           cur_job;
  rslr_pkg::bin_tag_t       cur_tag;

  // config port
  assign pready = 1'b1;

  always_comb begin
    unique case (rslr_pkg::reg_idx_e'(paddr[4:3]))
      rslr_pkg::REG_COARSE:  prdata = 64'(coarse_q);
      rslr_pkg::REG_FIRST:   prdata = 64'(first_q);
      rslr_pkg::REG_LAST:    prdata = 64'(last_q);
      rslr_pkg::REG_TRIGGER: prdata = 64'(trigger_q);
      default:               prdata = '0;
    endcase
  end

  assign s_acc = s_axis_tvalid && s_axis_tready;

  // row decision: which bins come out and how the open bin moves on
  always_comb begin : p_next
    logic [49:0]          r_start, r_stop;
    logic [24:0]          r_expo;
    logic [NCH-1:0][23:0] r_cnt;
    logic                 r_last;
    logic [49:0]          r_dur;
    logic [25:0]          bound;
    logic                 fine;
    logic [1:0]           n;
    rslr_pkg::bin_t       b;
    logic [50:0]          dsum;
    logic [25:0]          esum;
    logic [24:0]          csum;

    r_start = s_axis_tdata[49:0];
    r_stop  = s_axis_tdata[99:50];
    r_expo  = s_axis_tdata[124:100];
    r_last  = s_axis_tlast;
    for (int c = 0; c < NCH; c++) begin
      r_cnt[c] = (c < CHANNELS) ? {8'b0, s_axis_tdata[125 + 16*c +: 16]} : 24'd0;
    end
    r_dur = (r_stop >= r_start) ? 50'(r_stop - r_start) : 50'd0;
    bound = 26'(coarse_q) + rslr_pkg::MARGIN_US;
    fine  = (32'(rc_q) >= 32'(first_q)) && (32'(rc_q) <= 32'(last_q));
    n     = 2'd0;
    b     = '0;
    dsum  = '0;
    esum  = '0;
    csum  = '0;

    rc_d     = rc_q;
    open_d   = open_q;
    acc_d    = acc_q;
    expo_d   = expo_q;
    dur_d    = dur_q;
    ostart_d = ostart_q;
    ostop_d  = ostop_q;
    njobs_d  = njobs_q;
    job0_d   = job_q[0];
    job1_d   = job_q[1];

    if (s_acc) begin
      if (fine) begin
        if (open_d) begin
          b = '{start: ostart_d, stop: ostop_d, counts: acc_d, expo: expo_d,
                trig: 1'b0, seg: 1'b0};
          if (n == 2'd0) job0_d = b; else job1_d = b;
          n = n + 2'd1;
          open_d = 1'b0; acc_d = '0; expo_d = '0; dur_d = '0;
          ostart_d = '0; ostop_d = '0;
        end
        b = '{start: r_start, stop: r_stop, counts: r_cnt, expo: r_expo,
              trig: (trigger_q >= r_start) && (trigger_q <= r_stop), seg: 1'b0};
        if (n == 2'd0) job0_d = b; else job1_d = b;
        n = n + 2'd1;
      end else begin
        dsum = 51'(dur_d) + 51'(r_dur);
        if (open_d && dsum >= 51'(bound)) begin
          b = '{start: ostart_d, stop: ostop_d, counts: acc_d, expo: expo_d,
                trig: 1'b0, seg: 1'b0};
          if (n == 2'd0) job0_d = b; else job1_d = b;
          n = n + 2'd1;
          open_d = 1'b0; acc_d = '0; expo_d = '0; dur_d = '0;
          ostart_d = '0; ostop_d = '0;
        end
        if (!open_d && r_dur >= 50'(bound)) begin
          // a row at least as long as the target is a bin of its own
          b = '{start: r_start, stop: r_stop, counts: r_cnt, expo: r_expo,
                trig: 1'b0, seg: 1'b0};
          if (n == 2'd0) job0_d = b; else job1_d = b;
          n = n + 2'd1;
        end else begin
          if (!open_d) begin
            open_d   = 1'b1;
            ostart_d = r_start;
          end
          for (int c = 0; c < NCH; c++) begin
            csum = 25'(acc_d[c]) + 25'(r_cnt[c]);
            acc_d[c] = csum[24] ? 24'hFFFFFF : csum[23:0];
          end
          esum   = 26'(expo_d) + 26'(r_expo);
          expo_d = esum[25] ? 25'h1FFFFFF : esum[24:0];
          dsum   = 51'(dur_d) + 51'(r_dur);
          dur_d  = (dsum > 51'h1FFFFFF) ? 25'h1FFFFFF : dsum[24:0];
          ostop_d = r_stop;
        end
      end

      if (r_last) begin
        if (open_d) begin
          b = '{start: ostart_d, stop: ostop_d, counts: acc_d, expo: expo_d,
                trig: 1'b0, seg: 1'b0};
          if (n == 2'd0) job0_d = b; else job1_d = b;
          n = n + 2'd1;
        end
        open_d = 1'b0; acc_d = '0; expo_d = '0; dur_d = '0;
        ostart_d = '0; ostop_d = '0;
        rc_d = '0;
        if (n == 2'd1) job0_d.seg = 1'b1;
        else if (n == 2'd2) job1_d.seg = 1'b1;
      end else if (32'(rc_q) < ROW_LIMIT) begin
        rc_d = rc_q + RCW'(1);
      end
      njobs_d = n;
    end
  end

  assign s_axis_tready = (state_q == S_IDLE);
  assign lane_start    = (state_q == S_LOAD);
  assign merge_load    = (state_q == S_PUT) && merge_ready;
  assign cur_job       = job_q[k_q];
  assign cur_tag       = '{start: cur_job.start, stop: cur_job.stop,
                           trig: cur_job.trig, seg: cur_job.seg};

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      state_q   <= S_IDLE;
      k_q       <= 1'b0;
      njobs_q   <= '0;
      job_q[0]  <= '0;
      job_q[1]  <= '0;
      coarse_q  <= rslr_pkg::COARSE_RST;
      first_q   <= '0;
      last_q    <= '0;
      trigger_q <= '0;
      rc_q      <= '0;
      open_q    <= 1'b0;
      acc_q     <= '0;
      expo_q    <= '0;
      dur_q     <= '0;
      ostart_q  <= '0;
      ostop_q   <= '0;
    end else begin
      if (psel && penable && pwrite) begin
        unique case (rslr_pkg::reg_idx_e'(paddr[4:3]))
          rslr_pkg::REG_COARSE:  coarse_q  <= pwdata[24:0];
          rslr_pkg::REG_FIRST:   first_q   <= pwdata[11:0];
          rslr_pkg::REG_LAST:    last_q    <= pwdata[11:0];
          rslr_pkg::REG_TRIGGER: trigger_q <= pwdata[49:0];
          default: ;
        endcase
      end
      rc_q     <= rc_d;
      open_q   <= open_d;
      acc_q    <= acc_d;
      expo_q   <= expo_d;
      dur_q    <= dur_d;
      ostart_q <= ostart_d;
      ostop_q  <= ostop_d;
      njobs_q  <= njobs_d;
      job_q[0] <= job0_d;
      job_q[1] <= job1_d;
      unique case (state_q)
        S_IDLE: begin
          if (s_acc && njobs_d != 2'd0) begin
            k_q     <= 1'b0;
            state_q <= S_LOAD;
          end
        end
        S_LOAD: state_q <= S_DIV;
        S_DIV: begin
          if (lane_busy == '0) state_q <= S_PUT;
        end
        S_PUT: begin
          if (merge_ready) begin
            if (!k_q && njobs_q == 2'd2) begin
              k_q     <= 1'b1;
              state_q <= S_LOAD;
            end else begin
              state_q <= S_IDLE;
            end
          end
        end
        default: state_q <= S_IDLE;
      endcase
    end
  end

  for (genvar c = 0; c < NCH; c++) begin : g_lane
    if (c < CHANNELS) begin : g_on
      rslr_lane u_lane (
        .clk_i    (clk_i),
        .rst_ni   (rst_ni),
        .start_i  (lane_start),
        .counts_i (cur_job.counts[c]),
        .expo_i   (cur_job.expo),
        .busy_o   (lane_busy[c]),
        .rate_o   (rates[c])
      );
    end else begin : g_off
      assign lane_busy[c] = 1'b0;
      assign rates[c]     = '0;
    end
  end

  rslr_merge u_merge (
    .clk_i         (clk_i),
    .rst_ni        (rst_ni),
    .load_i        (merge_load),
    .tag_i         (cur_tag),
    .rates_i       (rates),
    .ready_o       (merge_ready),
    .m_axis_tvalid (m_axis_tvalid),
    .m_axis_tready (m_axis_tready),
    .m_axis_tdata  (m_axis_tdata),
    .m_axis_tlast  (m_axis_tlast),
    .m_axis_tuser  (m_axis_tuser)
  );

endmodule

### design/rslr_checker.sv
`include "assert_macros.svh"

module rslr_checker (
  input logic        clk_i,
  input logic        rst_ni,
  input logic        s_axis_tvalid,
  input logic        s_axis_tready,
  input logic        s_axis_tlast,
  input logic        m_axis_tvalid,
  input logic        m_axis_tready,
  input logic        psel,
  input logic        pwrite,
  input logic [4:0]  paddr,
  input logic [63:0] prdata,
  input logic        pready
);

  `RSLR_ASSERT_ALWAYS(a_pready_high, clk_i, pready)

  `RSLR_ASSERT(a_out_hold, clk_i, rst_ni, m_axis_tvalid && !m_axis_tready |=> m_axis_tvalid)

  // a segment end always yields a bin, so the input must close behind it
  `RSLR_ASSERT(a_last_busy, clk_i, rst_ni, s_axis_tvalid && s_axis_tready && s_axis_tlast |=> !s_axis_tready)

  `RSLR_ASSERT(a_coarse_width, clk_i, rst_ni, psel && !pwrite && paddr[4:3] == rslr_pkg::REG_COARSE |-> prdata[63:25] == '0)

endmodule

bind spectrum_livetime_rebinner_unit rslr_checker u_rslr_checker (.*);
